### hdl/vdeq_pkg.sv
// Shared types and constants of the validated double-ended queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vdeq_pkg;

    localparam int PASS_W = 17;
    localparam int SEAT_W = 8;
    localparam int NAME_W = 16;
    localparam int OCC_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [PASS_W-1:0] MAX_PASSPORT_RST = 17'd88000;
    localparam logic [SEAT_W-1:0] MAX_SEAT_RST     = 8'd150;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PASSPORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEAT     = 1'b1;

    typedef enum logic [1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [PASS_W-1:0] passport;
        logic [SEAT_W-1:0] seat;
        logic [NAME_W-1:0] name;
    } entry_t;

    typedef struct packed {
        status_t          status;
        entry_t           popped;
        entry_t           head;
        entry_t           tail;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage

`default_nettype wire

### hdl/vdeq_in_if.sv
// Request channel of the queue: one action and the fields of an entry.
// Depends on vdeq_pkg for the field widths.
`default_nettype none

interface vdeq_in_if import vdeq_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [PASS_W-1:0] passport;
    logic [SEAT_W-1:0] seat;
    logic [NAME_W-1:0] name_handle;

    modport source (output valid, action, passport, seat, name_handle, input ready);
    modport sink   (input valid, action, passport, seat, name_handle, output ready);
endinterface

`default_nettype wire

### hdl/vdeq_out_if.sv
// Result channel of the queue: status, popped entry, head, tail and count.
// Depends on vdeq_pkg for the field widths.
`default_nettype none

interface vdeq_out_if import vdeq_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PASS_W-1:0] popped_passport;
    logic [SEAT_W-1:0] popped_seat;
    logic [NAME_W-1:0] popped_name;
    logic [PASS_W-1:0] head_passport;
    logic [SEAT_W-1:0] head_seat;
    logic [NAME_W-1:0] head_name;
    logic [PASS_W-1:0] tail_passport;
    logic [SEAT_W-1:0] tail_seat;
    logic [NAME_W-1:0] tail_name;
    logic [OCC_W-1:0]  occupancy;

    modport source (
        output valid, status, popped_passport, popped_seat, popped_name,
               head_passport, head_seat, head_name,
               tail_passport, tail_seat, tail_name, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, popped_passport, popped_seat, popped_name,
               head_passport, head_seat, head_name,
               tail_passport, tail_seat, tail_name, occupancy,
        output ready
    );
endinterface

`default_nettype wire

### hdl/vdeq_ring.sv
// Ring storage of the queue entries: one write port, one registered read port.
// Depends on vdeq_pkg for the entry type.
`default_nettype none

module vdeq_ring import vdeq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire entry_t                   wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output entry_t                        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/validated_double_ended_queue.sv
// A request transfer is registered in stage_reg and then in out_reg before its
// result shows on rsp. Throughput: one request per cycle while rsp is taken; the
// head entry after a pop front comes from the single registered read port of the
// ring memory, which never blocks the next request.
// Reset empties the queue, drops both pipeline stages and restores the
// passport and seat limits to 88000 and 150.
`default_nettype none

module validated_double_ended_queue import vdeq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    vdeq_in_if.sink                    req,
    vdeq_out_if.source                 rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        result_t res;
        logic    head_from_mem;
    } stage_t;

    logic [PASS_W-1:0] max_pass_reg;
    logic [SEAT_W-1:0] max_seat_reg;

    logic [IW-1:0] head_idx_reg, head_idx_next;
    logic [IW-1:0] tail_idx_reg, tail_idx_next;
    logic [CW-1:0] count_reg, count_next;
    entry_t        head_ent_reg, head_ent_next;
    entry_t        tail_ent_reg, tail_ent_next;
    logic          head_mem_reg, head_mem_next;

    stage_t  stage_reg, stage_next;
    logic    stage_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;

    logic    accept, advance;
    action_t act;
    entry_t  fresh, head_cur, popped, rd_data;
    status_t status;
    logic    is_empty, is_full, fields_ok;
    logic [IW-1:0] head_inc, head_dec, tail_inc, wr_addr;
    logic    wr_en, rd_en;

    // Limits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pass_reg <= MAX_PASSPORT_RST;
            max_seat_reg <= MAX_SEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_PASSPORT: max_pass_reg <= cfg_data[PASS_W-1:0];
                REG_MAX_SEAT:     max_seat_reg <= cfg_data[SEAT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign advance   = stage_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !stage_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign act   = action_t'(req.action);
    assign fresh = '{passport: req.passport, seat: req.seat, name: req.name_handle};

    // After a pop front the head entry sits in the ring's read register.
    assign head_cur = head_mem_reg ? rd_data : head_ent_reg;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign fields_ok = (req.passport != '0) && (req.passport <= max_pass_reg)
                    && (req.seat != '0) && (req.seat <= max_seat_reg);

    assign head_inc = (head_idx_reg == IW'(DEPTH - 1)) ? '0 : head_idx_reg + IW'(1);
    assign head_dec = (head_idx_reg == '0) ? IW'(DEPTH - 1) : head_idx_reg - IW'(1);
    assign tail_inc = (tail_idx_reg == IW'(DEPTH - 1)) ? '0 : tail_idx_reg + IW'(1);

    always_comb
    begin
        status        = ST_OK;
        popped        = '0;
        head_idx_next = head_idx_reg;
        tail_idx_next = tail_idx_reg;
        count_next    = count_reg;
        head_ent_next = head_cur;
        tail_ent_next = tail_ent_reg;
        head_mem_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = head_idx_reg;
        rd_en         = 1'b0;
        case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else if (!fields_ok)
                begin
                    status = ST_INVALID;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (is_empty)
                    begin
                        tail_idx_next = head_idx_reg;
                        wr_addr       = head_idx_reg;
                        head_ent_next = fresh;
                        tail_ent_next = fresh;
                    end
                    else if (act == ACT_PUSH_BACK)
                    begin
                        tail_idx_next = tail_inc;
                        wr_addr       = tail_inc;
                        tail_ent_next = fresh;
                    end
                    else
                    begin
                        head_idx_next = head_dec;
                        wr_addr       = head_dec;
                        head_ent_next = fresh;
                    end
                end
            end
            ACT_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    popped     = head_cur;
                    count_next = count_reg - CW'(1);
                    // Popping the last entry leaves the indices where they are.
                    if (count_reg != CW'(1))
                    begin
                        head_idx_next = head_inc;
                        rd_en         = 1'b1;
                        head_mem_next = 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                count_next    = '0;
                head_idx_next = '0;
                tail_idx_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stage_next.res.status    = status;
        stage_next.res.popped    = popped;
        stage_next.res.occupancy = OCC_W'(count_next);
        if (count_next == '0)
        begin
            stage_next.res.head      = '0;
            stage_next.res.tail      = '0;
            stage_next.head_from_mem = 1'b0;
        end
        else
        begin
            stage_next.res.head      = head_ent_next;
            stage_next.res.tail      = tail_ent_next;
            stage_next.head_from_mem = head_mem_next;
        end
    end

    vdeq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept && wr_en),
        .waddr (wr_addr),
        .wdata (fresh),
        .re    (accept && rd_en),
        .raddr (head_inc),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx_reg    <= '0;
            tail_idx_reg    <= '0;
            count_reg       <= '0;
            head_mem_reg    <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_idx_reg <= head_idx_next;
                tail_idx_reg <= tail_idx_next;
                count_reg    <= count_next;
                head_mem_reg <= head_mem_next;
            end
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_ent_reg <= head_ent_next;
            tail_ent_reg <= tail_ent_next;
            stage_reg    <= stage_next;
        end
        if (advance)
        begin
            out_reg.status    <= stage_reg.res.status;
            out_reg.popped    <= stage_reg.res.popped;
            out_reg.head      <= stage_reg.head_from_mem ? rd_data : stage_reg.res.head;
            out_reg.tail      <= stage_reg.res.tail;
            out_reg.occupancy <= stage_reg.res.occupancy;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.popped_passport = out_reg.popped.passport;
    assign rsp.popped_seat     = out_reg.popped.seat;
    assign rsp.popped_name     = out_reg.popped.name;
    assign rsp.head_passport   = out_reg.head.passport;
    assign rsp.head_seat       = out_reg.head.seat;
    assign rsp.head_name       = out_reg.head.name;
    assign rsp.tail_passport   = out_reg.tail.passport;
    assign rsp.tail_seat       = out_reg.tail.seat;
    assign rsp.tail_name       = out_reg.tail.name;
    assign rsp.occupancy       = out_reg.occupancy;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'(1) |-> head_idx_reg == tail_idx_reg)
        else $error("single entry but head and tail indices differ");

    a_head_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        head_mem_reg |-> count_reg != '0)
        else $error("head taken from ring read while queue empty");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(DEPTH))
        else $error("full status with wrong occupancy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY
        |-> rsp.occupancy == '0 && rsp.head_passport == '0 && rsp.tail_passport == '0)
        else $error("empty status with nonzero head, tail or occupancy");
`endif

endmodule

`default_nettype wire
